>>> rtl/i2cmq_pkg.sv
// Shared types, codes and defaults for the I2C message queue sequencer.
// No dependencies; used by every module of the block.
`default_nettype none

package i2cmq_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 8;
    localparam int ENTRY_W   = 17;
    localparam int TAG_W     = 8;
    localparam int ATT_W     = 8;
    localparam int TIMER_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int COUNT_OUT_W = 4;
    localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd1000;

    typedef enum logic [1:0] {
        REQ_ENQUEUE = 2'd0,
        REQ_SERVICE = 2'd1,
        REQ_TICK    = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        OUTCOME_BUSY = 2'd0,
        OUTCOME_OK   = 2'd1
    } outcome_t;

    typedef enum logic [3:0] {
        ACT_NONE     = 4'd0,
        ACT_ACCEPT   = 4'd1,
        ACT_REJECT   = 4'd2,
        ACT_FETCH    = 4'd3,
        ACT_START    = 4'd4,
        ACT_DRIVE    = 4'd5,
        ACT_RETRY    = 4'd6,
        ACT_COMPLETE = 4'd7,
        ACT_CANCEL   = 4'd8,
        ACT_TIMEOUT  = 4'd9
    } action_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_FULL     = 2'd1,
        ERR_ATTEMPTS = 2'd2,
        ERR_BUS_OFF  = 2'd3
    } err_t;

    typedef enum logic [1:0] {
        PH_QUEUED = 2'd0,
        PH_XFER   = 2'd1,
        PH_CANCEL = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        CFG_BUS1_EN  = 2'd0,
        CFG_BUS2_EN  = 2'd1,
        CFG_TIMEOUT  = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_READ = 2'd1,
        ST_EXEC = 2'd2
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
    } cmd_t;

    typedef struct packed {
        logic out_full;
    } status_t;

    function automatic logic bus_on(input logic bus, input logic b1_en, input logic b2_en);
        return bus ? b2_en : b1_en;
    endfunction

endpackage

`default_nettype wire

>>> rtl/i2c_message_queue_retry.sv
// A result is registered after its item is accepted, by way of the ring read and execute states.
// No new item is accepted until the last one has passed the registered read of the ring at the head and execute.
// A waiting result holds the next item in execute; no further item is accepted until it is taken.
// Reset (aresetn low, synchronous): queue empty, no current message, timer stopped,
// both buses enabled, timeout 1000 ticks. The ring contents are not cleared.
// Neither items nor register writes are accepted while aresetn is low.
`default_nettype none

module i2c_message_queue_retry #(
    parameter int QUEUE_DEPTH = i2cmq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [23:0] s_tdata,   // msg_tag[7:0], target_bus[8], attempt_budget[16:9],
                                   // outcome[18:17], zero[23:19]
    input  wire  [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata,   // out_tag[7:0], out_bus[8], error_code[10:9],
                                   // stop_request[11], queued_count[15:12]
    output logic [3:0]  m_tuser,   // action[3:0]
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [i2cmq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire  [i2cmq_pkg::CFG_DAT_W-1:0] cfg_data
);

    i2cmq_pkg::cmd_t    cmd;
    i2cmq_pkg::status_t status;

    assign cfg_ready = aresetn;

    i2cmq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    i2cmq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .in_req     (s_tuser),
        .in_tag     (s_tdata[7:0]),
        .in_bus     (s_tdata[8]),
        .in_budget  (s_tdata[16:9]),
        .in_outcome (s_tdata[18:17]),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_action   (m_tuser),
        .m_tag      (m_tdata[7:0]),
        .m_bus      (m_tdata[8]),
        .m_error    (m_tdata[10:9]),
        .m_stop     (m_tdata[11]),
        .m_count    (m_tdata[15:12])
    );

endmodule

`default_nettype wire

>>> rtl/i2cmq_ctrl.sv
// Sequencing state machine: capture an item, wait for the ring read, execute.
// Depends on i2cmq_pkg.
`default_nettype none

module i2cmq_ctrl (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_tvalid,
    output logic                  s_tready,
    input  i2cmq_pkg::status_t    status,
    output i2cmq_pkg::cmd_t       cmd
);

    i2cmq_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= i2cmq_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
        case (state_reg)
            i2cmq_pkg::ST_IDLE: begin
                s_tready = aresetn;
                if (s_tvalid && aresetn) begin
                    cmd.capture = 1'b1;
                    state_next  = i2cmq_pkg::ST_READ;
                end
            end
            i2cmq_pkg::ST_READ: begin
                state_next = i2cmq_pkg::ST_EXEC;
            end
            i2cmq_pkg::ST_EXEC: begin
                if (!status.out_full) begin
                    cmd.exec   = 1'b1;
                    state_next = i2cmq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = i2cmq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/i2cmq_datapath.sv
// Ring store, queue and current-message registers, timer and result register.
// Depends on i2cmq_pkg; driven by commands from i2cmq_ctrl.
`default_nettype none

module i2cmq_datapath #(
    parameter int QUEUE_DEPTH = i2cmq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  i2cmq_pkg::cmd_t                       cmd,
    output i2cmq_pkg::status_t                    status,
    input  wire  [1:0]                            in_req,
    input  wire  [i2cmq_pkg::TAG_W-1:0]           in_tag,
    input  wire                                   in_bus,
    input  wire  [i2cmq_pkg::ATT_W-1:0]           in_budget,
    input  wire  [1:0]                            in_outcome,
    input  wire                                   cfg_valid,
    input  wire  [i2cmq_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [i2cmq_pkg::CFG_DAT_W-1:0]       cfg_data,
    output logic                                  m_valid,
    input  wire                                   m_ready,
    output logic [3:0]                            m_action,
    output logic [i2cmq_pkg::TAG_W-1:0]           m_tag,
    output logic                                  m_bus,
    output logic [1:0]                            m_error,
    output logic                                  m_stop,
    output logic [i2cmq_pkg::COUNT_OUT_W-1:0]     m_count
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int TW = i2cmq_pkg::TIMER_W;
    localparam int AW = i2cmq_pkg::ATT_W;

    // configuration
    logic          bus1_en_reg, bus2_en_reg;
    logic [TW-1:0] timeout_reg;

    // captured item
    logic [1:0]              req_reg;
    logic [i2cmq_pkg::TAG_W-1:0] tag_reg;
    logic                    bus_reg;
    logic signed [AW-1:0]    budget_reg;
    logic [1:0]              outcome_reg;

    // ring
    logic [i2cmq_pkg::ENTRY_W-1:0] ring_mem [QUEUE_DEPTH];
    logic [i2cmq_pkg::ENTRY_W-1:0] rd_data_reg;
    logic                          mem_we;

    // queue and current message
    logic [PW-1:0]        head_reg, head_next, tail_reg, tail_next;
    logic [CW-1:0]        count_reg, count_next;
    logic                 valid_reg, valid_next;
    i2cmq_pkg::phase_t    phase_reg, phase_next;
    logic signed [AW-1:0] att_reg, att_next;
    logic [TW-1:0]        timer_reg, timer_next, timer_inc;
    logic                 run_reg, run_next;

    // result
    logic                        m_valid_reg;
    i2cmq_pkg::action_t          act;
    i2cmq_pkg::err_t             err;
    logic [i2cmq_pkg::TAG_W-1:0] otag;
    logic                        obus, stop;

    logic [i2cmq_pkg::TAG_W-1:0] cur_tag;
    logic                        cur_bus;
    logic signed [AW-1:0]        cur_att;

    assign cur_tag = rd_data_reg[7:0];
    assign cur_bus = rd_data_reg[8];
    assign cur_att = rd_data_reg[16:9];

    assign status.out_full = m_valid_reg && !m_ready;
    assign m_valid         = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bus1_en_reg <= 1'b1;
            bus2_en_reg <= 1'b1;
            timeout_reg <= i2cmq_pkg::TIMEOUT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                i2cmq_pkg::CFG_BUS1_EN: bus1_en_reg <= cfg_data[0];
                i2cmq_pkg::CFG_BUS2_EN: bus2_en_reg <= cfg_data[0];
                i2cmq_pkg::CFG_TIMEOUT: timeout_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg     <= in_req;
            tag_reg     <= in_tag;
            bus_reg     <= in_bus;
            budget_reg  <= in_budget;
            outcome_reg <= in_outcome;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ring_mem[tail_reg] <= {budget_reg, bus_reg, tag_reg};
        end
        rd_data_reg <= ring_mem[head_reg];
    end

    assign timer_inc = (timer_reg == {TW{1'b1}}) ? timer_reg : timer_reg + TW'(1);

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        valid_next = valid_reg;
        phase_next = phase_reg;
        att_next   = att_reg;
        timer_next = timer_reg;
        run_next   = run_reg;
        mem_we     = 1'b0;
        act        = i2cmq_pkg::ACT_NONE;
        err        = i2cmq_pkg::ERR_NONE;
        otag       = '0;
        obus       = 1'b0;
        stop       = 1'b0;
        case (req_reg)
            i2cmq_pkg::REQ_ENQUEUE: begin
                otag = tag_reg;
                obus = bus_reg;
                if (count_reg == CW'(QUEUE_DEPTH)) begin
                    act = i2cmq_pkg::ACT_REJECT;
                    err = i2cmq_pkg::ERR_FULL;
                end else if (budget_reg < 8'sd1) begin
                    act = i2cmq_pkg::ACT_REJECT;
                    err = i2cmq_pkg::ERR_ATTEMPTS;
                end else if (!i2cmq_pkg::bus_on(bus_reg, bus1_en_reg, bus2_en_reg)) begin
                    act = i2cmq_pkg::ACT_REJECT;
                    err = i2cmq_pkg::ERR_BUS_OFF;
                end else begin
                    act        = i2cmq_pkg::ACT_ACCEPT;
                    mem_we     = cmd.exec;
                    tail_next  = (tail_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + PW'(1);
                    count_next = count_reg + CW'(1);
                end
            end
            i2cmq_pkg::REQ_SERVICE: begin
                if (!valid_reg) begin
                    if (count_reg != '0) begin
                        act        = i2cmq_pkg::ACT_FETCH;
                        otag       = cur_tag;
                        obus       = cur_bus;
                        valid_next = 1'b1;
                        phase_next = i2cmq_pkg::PH_QUEUED;
                        att_next   = cur_att;
                    end
                end else begin
                    otag = cur_tag;
                    obus = cur_bus;
                    case (phase_reg)
                        i2cmq_pkg::PH_QUEUED: begin
                            act        = i2cmq_pkg::ACT_START;
                            phase_next = i2cmq_pkg::PH_XFER;
                            timer_next = '0;
                            run_next   = 1'b1;
                        end
                        i2cmq_pkg::PH_XFER: begin
                            if (outcome_reg == i2cmq_pkg::OUTCOME_BUSY) begin
                                act = i2cmq_pkg::ACT_DRIVE;
                            end else if (outcome_reg == i2cmq_pkg::OUTCOME_OK ||
                                         att_reg <= 8'sd0) begin
                                act        = i2cmq_pkg::ACT_COMPLETE;
                                run_next   = 1'b0;
                                head_next  = (head_reg == PW'(QUEUE_DEPTH - 1)) ?
                                             '0 : head_reg + PW'(1);
                                count_next = (count_reg != '0) ? count_reg - CW'(1) : count_reg;
                                valid_next = 1'b0;
                                phase_next = i2cmq_pkg::PH_QUEUED;
                            end else begin
                                act      = i2cmq_pkg::ACT_RETRY;
                                att_next = att_reg - 8'sd1;
                            end
                        end
                        default: begin
                            act        = i2cmq_pkg::ACT_CANCEL;
                            stop       = 1'b1;
                            head_next  = (head_reg == PW'(QUEUE_DEPTH - 1)) ?
                                         '0 : head_reg + PW'(1);
                            count_next = (count_reg != '0) ? count_reg - CW'(1) : count_reg;
                            valid_next = 1'b0;
                            phase_next = i2cmq_pkg::PH_QUEUED;
                        end
                    endcase
                end
            end
            i2cmq_pkg::REQ_TICK: begin
                if (run_reg && valid_reg) begin
                    timer_next = timer_inc;
                    if (timer_inc >= timeout_reg) begin
                        act        = i2cmq_pkg::ACT_TIMEOUT;
                        otag       = cur_tag;
                        obus       = cur_bus;
                        stop       = i2cmq_pkg::bus_on(cur_bus, bus1_en_reg, bus2_en_reg);
                        phase_next = i2cmq_pkg::PH_CANCEL;
                        att_next   = '0;
                        run_next   = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            valid_reg <= 1'b0;
            phase_reg <= i2cmq_pkg::PH_QUEUED;
            att_reg   <= '0;
            timer_reg <= '0;
            run_reg   <= 1'b0;
        end else if (cmd.exec) begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
            phase_reg <= phase_next;
            att_reg   <= att_next;
            timer_reg <= timer_next;
            run_reg   <= run_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.exec) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            m_action <= act;
            m_tag    <= otag;
            m_bus    <= obus;
            m_error  <= err;
            m_stop   <= stop;
            m_count  <= i2cmq_pkg::COUNT_OUT_W'(count_next);
        end
    end

`ifndef SYNTH
    a_timer_needs_msg: assert property (@(posedge aclk) disable iff (!aresetn)
        run_reg |-> valid_reg) else $error("timer running without a current message");
    a_msg_in_count: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> count_reg != '0) else $error("current message not counted");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(QUEUE_DEPTH)) else $error("entry count above depth");
    a_phase_needs_msg: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != i2cmq_pkg::PH_QUEUED |-> valid_reg)
        else $error("phase advanced without a current message");
    a_exec_loads_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |=> m_valid_reg) else $error("executed item left no result");
`endif

endmodule

`default_nettype wire
